### rtl/at_command_line_decoder_macros.svh
// assertion macros used by the checker file
`ifndef AT_COMMAND_LINE_DECODER_MACROS_SVH
`define AT_COMMAND_LINE_DECODER_MACROS_SVH

// checked only while out of reset
`define ATCL_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ATCL_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/atcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcl_pkg
// types, character codes and command patterns of the AT command line decoder
// ----------------------------------------------------------------------------
package atcl_pkg;

    localparam int LINE_MAX_DEFAULT = 64;

    localparam int BYTE_W   = 8;
    localparam int HEAD_LEN = 14;
    localparam int HEAD_IDX_W = 4;
    localparam int WIN_LEN  = 9;
    localparam int NPAT     = 5;
    localparam int LEN_W    = 6;
    localparam int SW_W     = 12;
    localparam int CODE_W   = 3;

    localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0d;
    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0a;
    localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_T    = 8'h54;
    localparam logic [BYTE_W-1:0] CHAR_PLUS = 8'h2b;
    localparam logic [BYTE_W-1:0] CHAR_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_1    = 8'h31;

    // pattern bit positions, also the match priority
    localparam int PAT_VER     = 0;
    localparam int PAT_RTOKEN  = 1;
    localparam int PAT_RSET    = 2;
    localparam int PAT_SW_SET  = 3;
    localparam int PAT_SW_READ = 4;

    typedef enum logic [CODE_W-1:0] {
        CMD_VER     = 3'd0,
        CMD_FACTORY = 3'd1,
        CMD_RESET   = 3'd2,
        CMD_SET_SW  = 3'd3,
        CMD_READ_SW = 3'd4,
        CMD_ERROR   = 3'd5,
        CMD_NON_AT  = 3'd6
    } cmd_code_t;

    // win_t element 0 is the newest byte, head_t element 0 the first byte of the line
    typedef logic [WIN_LEN-1:0][BYTE_W-1:0]  win_t;
    typedef logic [HEAD_LEN-1:0][BYTE_W-1:0] head_t;

    // string literals are right aligned, so the last character lands in element 0
    localparam win_t PAT_TEXT [NPAT] = '{
        win_t'("AT+VER?"),
        win_t'("AT+RTOKEN"),
        win_t'("AT+RSET"),
        win_t'("AT+SW="),
        win_t'("AT+SW_R?")
    };
    localparam int PAT_LEN [NPAT] = '{7, 9, 7, 6, 8};

    typedef struct packed {
        head_t                 head;
        logic [NPAT-1:0]       pat;
        logic [LEN_W-1:0]      length;
    } line_info_t;

    function automatic logic [NPAT-1:0] pattern_hits(input win_t w);
        logic [NPAT-1:0] hits;
        hits = '1;
        for (int p = 0; p < NPAT; p++)
        begin
            for (int j = 0; j < WIN_LEN; j++)
            begin
                if ((j < PAT_LEN[p]) && (w[j] != PAT_TEXT[p][j]))
                begin
                    hits[p] = 1'b0;
                end
            end
        end
        return hits;
    endfunction

    function automatic logic is_digit01(input logic [BYTE_W-1:0] b);
        return (b == CHAR_0) || (b == CHAR_1);
    endfunction

endpackage

### rtl/atcl_rx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcl_rx_if
// received byte channel
// ----------------------------------------------------------------------------
interface atcl_rx_if;
    import atcl_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/atcl_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcl_cmd_if
// decoded command channel
// ----------------------------------------------------------------------------
interface atcl_cmd_if;
    import atcl_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] cmd_code;
    logic [SW_W-1:0]   switch_state;
    logic [LEN_W-1:0]  line_length;
    logic              reset_request;
    logic              factory_clear;

    modport source (output valid, output cmd_code, output switch_state,
                    output line_length, output reset_request, output factory_clear,
                    input ready);
    modport sink   (input valid, input cmd_code, input switch_state,
                    input line_length, input reset_request, input factory_clear,
                    output ready);
endinterface

### rtl/at_command_line_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_command_line_decoder
// collects CR LF framed serial lines and decodes AT commands
// ----------------------------------------------------------------------------
//  channel   dir   carries
//  rx        in    rx_byte, one received byte per transaction
//  cmd       out   cmd_code, switch_state, line_length, reset_request,
//                  factory_clear, one transaction per completed line
//
//  one byte accepted per cycle unless rx stalls; the line state updates at the accepting edge
//  a result goes through the line hand-off register, then the output register, to cmd
//  line hand-off register plus output register: rx stalls only when both hold
//  reset clears the collection state, valid flags and switch register, no clearing pass
// ----------------------------------------------------------------------------
module at_command_line_decoder #(
    parameter int LINE_MAX = atcl_pkg::LINE_MAX_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    atcl_rx_if.sink     rx,
    atcl_cmd_if.source  cmd
);
    import atcl_pkg::*;

    logic       line_valid;
    logic       line_take;
    line_info_t line_info;

    atcl_collect #(
        .LINE_MAX (LINE_MAX)
    ) u_collect (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .line_valid (line_valid),
        .line_info  (line_info),
        .line_take  (line_take)
    );

    atcl_classify u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_valid (line_valid),
        .line_info  (line_info),
        .line_take  (line_take),
        .cmd        (cmd)
    );

endmodule

### rtl/atcl_collect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcl_collect
// gathers line bytes, tracks CR/LF framing and pattern hits, hands off lines
// ----------------------------------------------------------------------------
module atcl_collect #(
    parameter int LINE_MAX = atcl_pkg::LINE_MAX_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    atcl_rx_if.sink              rx,
    output logic                 line_valid,
    output atcl_pkg::line_info_t line_info,
    input  logic                 line_take
);
    import atcl_pkg::*;

    localparam int CNT_W = $clog2(LINE_MAX);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             cr_reg, cr_next;
    head_t            head_reg, head_next;
    win_t             win_reg, win_next;
    logic [NPAT-1:0]  pat_reg, pat_next;
    logic             nul_reg, nul_next;
    logic             snap_valid_reg, snap_valid_next;
    line_info_t       snap_reg, snap_next;

    win_t             win_shift;
    logic             accept;

    assign rx.ready   = !snap_valid_reg || line_take;
    assign accept     = rx.valid && rx.ready;
    assign line_valid = snap_valid_reg;
    assign line_info  = snap_reg;
    assign win_shift  = {win_reg[WIN_LEN-2:0], rx.rx_byte};

    always_comb
    begin
        count_next      = count_reg;
        cr_next         = cr_reg;
        head_next       = head_reg;
        win_next        = win_reg;
        pat_next        = pat_reg;
        nul_next        = nul_reg;
        snap_valid_next = snap_valid_reg && !line_take;
        snap_next       = snap_reg;
        if (accept)
        begin
            if (cr_reg)
            begin
                // LF completes the line, anything else drops it
                if (rx.rx_byte == CHAR_LF)
                begin
                    snap_valid_next  = 1'b1;
                    snap_next.head   = head_reg;
                    snap_next.pat    = pat_reg;
                    snap_next.length = LEN_W'(count_reg);
                end
                count_next = '0;
                cr_next    = 1'b0;
                head_next  = '0;
                win_next   = '0;
                pat_next   = '0;
                nul_next   = 1'b0;
            end
            else if (rx.rx_byte == CHAR_CR)
            begin
                cr_next = 1'b1;
            end
            else
            begin
                if (count_reg < CNT_W'(HEAD_LEN))
                begin
                    head_next[count_reg[HEAD_IDX_W-1:0]] = rx.rx_byte;
                end
                if (!nul_reg)
                begin
                    if (rx.rx_byte == CHAR_NUL)
                    begin
                        nul_next = 1'b1;
                    end
                    else
                    begin
                        win_next = win_shift;
                        pat_next = pat_reg | pattern_hits(win_shift);
                    end
                end
                count_next = count_reg + 1'b1;
                // overlong line is dropped
                if (count_reg == CNT_W'(LINE_MAX - 1))
                begin
                    count_next = '0;
                    head_next  = '0;
                    win_next   = '0;
                    pat_next   = '0;
                    nul_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            cr_reg         <= 1'b0;
            head_reg       <= '0;
            win_reg        <= '0;
            pat_reg        <= '0;
            nul_reg        <= 1'b0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            cr_reg         <= cr_next;
            head_reg       <= head_next;
            win_reg        <= win_next;
            pat_reg        <= pat_next;
            nul_reg        <= nul_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

endmodule

### rtl/atcl_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcl_classify
// turns a finished line into a command code, owns the switch register
// ----------------------------------------------------------------------------
module atcl_classify (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 line_valid,
    input  atcl_pkg::line_info_t line_info,
    output logic                 line_take,
    atcl_cmd_if.source           cmd
);
    import atcl_pkg::*;

    logic             out_valid_reg, out_valid_next;
    cmd_code_t        code_reg, code_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [SW_W-1:0]  switch_reg, switch_next;

    logic             out_load;
    logic             prefix_ok;
    logic             digits_ok;
    cmd_code_t        code;
    logic [SW_W-1:0]  sw_value;

    assign out_load  = !out_valid_reg || cmd.ready;
    assign line_take = line_valid && out_load;

    assign prefix_ok = (line_info.head[0] == CHAR_A) && (line_info.head[1] == CHAR_T)
                    && (line_info.head[2] == CHAR_PLUS);

    always_comb
    begin
        digits_ok = 1'b1;
        for (int i = 6; i < HEAD_LEN; i++)
        begin
            if (!is_digit01(line_info.head[i]))
            begin
                digits_ok = 1'b0;
            end
        end
    end

    // first four digits go to bits 11..8, last four to bits 3..0
    assign sw_value = {line_info.head[6][0], line_info.head[7][0],
                       line_info.head[8][0], line_info.head[9][0], 4'b0000,
                       line_info.head[10][0], line_info.head[11][0],
                       line_info.head[12][0], line_info.head[13][0]};

    always_comb
    begin
        priority if (!prefix_ok)
            code = CMD_NON_AT;
        else if (line_info.pat[PAT_VER])
            code = CMD_VER;
        else if (line_info.pat[PAT_RTOKEN])
            code = CMD_FACTORY;
        else if (line_info.pat[PAT_RSET])
            code = CMD_RESET;
        else if (line_info.pat[PAT_SW_SET] && !digits_ok)
            code = CMD_ERROR;
        else if (line_info.pat[PAT_SW_SET] && (line_info.head[13] == CHAR_0))
            code = CMD_SET_SW;
        else if (line_info.pat[PAT_SW_READ])
            code = CMD_READ_SW;
        else
            code = CMD_ERROR;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !cmd.ready;
        code_next      = code_reg;
        len_next       = len_reg;
        switch_next    = switch_reg;
        if (line_take)
        begin
            out_valid_next = 1'b1;
            code_next      = code;
            len_next       = line_info.length;
            if (code == CMD_SET_SW)
            begin
                switch_next = sw_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            switch_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            switch_reg    <= switch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        len_reg  <= len_next;
    end

    // switch_reg only moves when a new result loads, so it matches the held result
    assign cmd.valid         = out_valid_reg;
    assign cmd.cmd_code      = code_reg;
    assign cmd.switch_state  = switch_reg;
    assign cmd.line_length   = len_reg;
    assign cmd.reset_request = (code_reg == CMD_FACTORY) || (code_reg == CMD_RESET);
    assign cmd.factory_clear = (code_reg == CMD_FACTORY);

endmodule

### rtl/atcl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atcl_checker
// port level checks on the decoded command channel
// ----------------------------------------------------------------------------
`include "at_command_line_decoder_macros.svh"

module atcl_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cmd_valid,
    input logic                      cmd_ready,
    input logic [atcl_pkg::CODE_W-1:0] cmd_code,
    input logic [atcl_pkg::SW_W-1:0]   switch_state,
    input logic [atcl_pkg::LEN_W-1:0]  line_length,
    input logic                      reset_request,
    input logic                      factory_clear
);
    import atcl_pkg::*;

    // stalled result holds
    `ATCL_ASSERT(a_cmd_hold, clk, rst_n,
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_code)
            && $stable(switch_state) && $stable(line_length),
        "cmd result changed while stalled")

    `ATCL_ASSERT(a_factory_flags, clk, rst_n,
        cmd_valid && factory_clear |-> reset_request && (cmd_code == CMD_FACTORY),
        "factory_clear without factory command")

    `ATCL_ASSERT(a_reset_code, clk, rst_n,
        cmd_valid && reset_request |-> (cmd_code == CMD_FACTORY) || (cmd_code == CMD_RESET),
        "reset_request on wrong command")

    // middle nibble of the switch register is only ever loaded with zeros
    `ATCL_ASSERT_ALWAYS(a_switch_gap, clk, !rst_n || (switch_state[7:4] == 4'b0000),
        "switch bits 7..4 set")

endmodule

bind at_command_line_decoder atcl_checker u_atcl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .cmd_code      (cmd.cmd_code),
    .switch_state  (cmd.switch_state),
    .line_length   (cmd.line_length),
    .reset_request (cmd.reset_request),
    .factory_clear (cmd.factory_clear)
);
